@@ sv/hcu_pkg.sv @@
// Shared types and constants for the class histogram counter.
package hcu_pkg;

  localparam int unsigned MAX_CLASSES = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned IDX_W       = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned LOAD_W      = $clog2(MAX_CLASSES + 1);

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_PIXEL  = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MATCH   = 6'b000010,
    ST_READ    = 6'b000100,
    ST_WRITE   = 6'b001000,
    ST_RD_WAIT = 6'b010000,
    ST_RD_OUT  = 6'b100000
  } state_e;

  typedef struct packed {
    logic clear;
    logic append;
    logic latch_pixel;
    logic match;
    logic cnt_write;
    logic rd_start;
    logic rd_sel;
    logic rd_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic rd_last;
    logic out_busy;
  } sts_t;

endpackage

@@ sv/hcu_in_if.sv @@
// Request channel carrying action and item value.
interface hcu_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            action;
  logic signed [hcu_pkg::VAL_W-1:0]      item_value;

  modport source (output valid, output action, output item_value, input ready);
  modport sink   (input valid, input action, input item_value, output ready);
endinterface

@@ sv/hcu_out_if.sv @@
// Result channel carrying class value, count and last marker.
interface hcu_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [hcu_pkg::VAL_W-1:0]      class_value;
  logic [hcu_pkg::CNT_W-1:0]             class_count;
  logic                                  last_entry;

  modport source (output valid, output class_value, output class_count,
                  output last_entry, input ready);
  modport sink   (input valid, input class_value, input class_count,
                  input last_entry, output ready);
endinterface

@@ sv/class_histogram_counter_unit.sv @@
// Top level of the class histogram counter.
// Start and append requests are taken while idle and leave the unit idle; a pixel
// request steps through compare, count RAM read, saturating increment and write back.
// A readout alternates a wait for the registered read port of the count RAM with
// loading one result into the output register, holding while the result side stalls.
// Reset (asynchronous, active low) empties the class table and marks all counts zero.
module class_histogram_counter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcu_in_if.sink     in_i,
  hcu_out_if.source  out_o
);

  hcu_pkg::cmd_t cmd;
  hcu_pkg::sts_t sts;
  logic          in_ready;

  assign in_i.ready = in_ready;

  hcu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .action_i   (in_i.action),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hcu_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_value_i (in_i.item_value),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_value_o  (out_o.class_value),
    .out_count_o  (out_o.class_count),
    .out_last_o   (out_o.last_entry)
  );

endmodule

@@ sv/hcu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module hcu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/hcu_ctrl.sv @@
// Controller state machine sequencing requests and readout.
module hcu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    action_i,
  output logic          in_ready_o,
  input  hcu_pkg::sts_t sts_i,
  output hcu_pkg::cmd_t cmd_o
);

  hcu_pkg::state_e state_q, state_d;
  hcu_pkg::action_e act;
  logic accept;

  assign act        = hcu_pkg::action_e'(action_i);
  assign in_ready_o = (state_q == hcu_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      hcu_pkg::ST_IDLE: begin
        if (accept) begin
          case (act)
            hcu_pkg::ACT_START:  cmd_o.clear = 1'b1;
            hcu_pkg::ACT_APPEND: cmd_o.append = 1'b1;
            hcu_pkg::ACT_PIXEL: begin
              cmd_o.latch_pixel = 1'b1;
              state_d = hcu_pkg::ST_MATCH;
            end
            hcu_pkg::ACT_READ: begin
              if (!sts_i.empty) begin
                cmd_o.rd_start = 1'b1;
                state_d = hcu_pkg::ST_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      hcu_pkg::ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d = hcu_pkg::ST_READ;
      end
      hcu_pkg::ST_READ: begin
        state_d = hcu_pkg::ST_WRITE;
      end
      hcu_pkg::ST_WRITE: begin
        cmd_o.cnt_write = 1'b1;
        state_d = hcu_pkg::ST_IDLE;
      end
      hcu_pkg::ST_RD_WAIT: begin
        cmd_o.rd_sel = 1'b1;
        state_d = hcu_pkg::ST_RD_OUT;
      end
      hcu_pkg::ST_RD_OUT: begin
        cmd_o.rd_sel = 1'b1;
        if (!sts_i.out_busy) begin
          cmd_o.rd_load = 1'b1;
          state_d = sts_i.rd_last ? hcu_pkg::ST_IDLE : hcu_pkg::ST_RD_WAIT;
        end
      end
      default: state_d = hcu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/hcu_dp.sv @@
// Datapath: class table, match logic, count RAM and result register.
module hcu_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [hcu_pkg::VAL_W-1:0]   item_value_i,
  input  hcu_pkg::cmd_t                      cmd_i,
  output hcu_pkg::sts_t                      sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [hcu_pkg::VAL_W-1:0]   out_value_o,
  output logic [hcu_pkg::CNT_W-1:0]          out_count_o,
  output logic                               out_last_o
);

  logic [hcu_pkg::VAL_W-1:0]  table_q [hcu_pkg::MAX_CLASSES];
  logic [hcu_pkg::MAX_CLASSES-1:0] cnt_vld_q;
  logic [hcu_pkg::LOAD_W-1:0] loaded_q;
  logic [hcu_pkg::VAL_W-1:0]  pixel_q;
  logic                       hit_q, hit_d;
  logic [hcu_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [hcu_pkg::IDX_W-1:0]  rd_idx_q;
  logic                       out_vld_q;
  logic [hcu_pkg::VAL_W-1:0]  out_value_q;
  logic [hcu_pkg::CNT_W-1:0]  out_count_q;
  logic                       out_last_q;

  logic                       full;
  logic [hcu_pkg::IDX_W-1:0]  raddr;
  logic [hcu_pkg::CNT_W-1:0]  rdata;
  logic [hcu_pkg::CNT_W-1:0]  cur_cnt;
  logic [hcu_pkg::CNT_W-1:0]  wdata;
  logic                       we;
  logic [hcu_pkg::CNT_W-1:0]  rd_cnt;

  assign full = (loaded_q == hcu_pkg::LOAD_W'(hcu_pkg::MAX_CLASSES));

  // first matching entry wins: scan from the top so lower indexes override
  always_comb begin
    hit_d = 1'b0;
    idx_d = '0;
    for (int i = hcu_pkg::MAX_CLASSES - 1; i >= 0; i--) begin
      if ((hcu_pkg::LOAD_W'(i) < loaded_q) && (table_q[i] == pixel_q)) begin
        hit_d = 1'b1;
        idx_d = hcu_pkg::IDX_W'(i);
      end
    end
  end

  assign raddr   = cmd_i.rd_sel ? rd_idx_q : idx_q;
  assign cur_cnt = cnt_vld_q[idx_q] ? rdata : '0;
  assign wdata   = (cur_cnt == hcu_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  assign we      = cmd_i.cnt_write && hit_q;
  assign rd_cnt  = cnt_vld_q[rd_idx_q] ? rdata : '0;

  hcu_ram #(
    .WIDTH (hcu_pkg::CNT_W),
    .DEPTH (hcu_pkg::MAX_CLASSES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sts_o.empty    = (loaded_q == '0);
  assign sts_o.rd_last  = ((hcu_pkg::LOAD_W'(rd_idx_q) + 1'b1) == loaded_q);
  assign sts_o.out_busy = out_vld_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      table_q[loaded_q[hcu_pkg::IDX_W-1:0]] <= item_value_i;
    end
    if (cmd_i.latch_pixel) begin
      pixel_q <= item_value_i;
    end
    if (cmd_i.match) begin
      hit_q <= hit_d;
      idx_q <= idx_d;
    end
    if (cmd_i.rd_load) begin
      out_value_q <= table_q[rd_idx_q];
      out_count_q <= rd_cnt;
      out_last_q  <= sts_o.rd_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      loaded_q  <= '0;
      rd_idx_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        cnt_vld_q <= '0;
        loaded_q  <= '0;
      end else if (cmd_i.append && !full) begin
        cnt_vld_q[loaded_q[hcu_pkg::IDX_W-1:0]] <= 1'b0;
        loaded_q <= loaded_q + 1'b1;
      end else if (we) begin
        cnt_vld_q[idx_q] <= 1'b1;
      end
      if (cmd_i.rd_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_load) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (cmd_i.rd_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_value_o = out_value_q;
  assign out_count_o = out_count_q;
  assign out_last_o  = out_last_q;

endmodule

@@ dv/tb_class_histogram_counter_unit.sv @@
// Self-checking testbench for the class histogram counter unit.
module tb_class_histogram_counter_unit;

  typedef struct packed {
    logic signed [hcu_pkg::VAL_W-1:0] class_value;
    logic [hcu_pkg::CNT_W-1:0]        class_count;
    logic                             last_entry;
  } hist_entry_t;

  typedef struct {
    hcu_pkg::action_e          act;
    logic [hcu_pkg::VAL_W-1:0] val;
    int                        n_typed;
    hist_entry_t               t0;
    hist_entry_t               t1;
  } stim_row_t;

  logic clk;
  logic rst_ni;

  hcu_in_if  in_if ();
  hcu_out_if out_if ();

  class_histogram_counter_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [hcu_pkg::VAL_W-1:0] model_classes [hcu_pkg::MAX_CLASSES];
  logic [hcu_pkg::CNT_W-1:0] model_counts  [hcu_pkg::MAX_CLASSES];
  int unsigned               model_loaded;
  hist_entry_t               expected_entries [$];
  stim_row_t                 directed_rows [$];

  int  error_count;
  int  results_checked;
  int  busy_items;
  int  n_start, n_append, n_pixel, n_read, n_full, n_hits, max_loaded;
  bit  send_burst;
  bit  recv_burst;
  bit  hold_arm;
  hist_entry_t got_entry;
  hist_entry_t exp_entry;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void apply_request(input hcu_pkg::action_e act,
                                        input logic [hcu_pkg::VAL_W-1:0] val,
                                        input bit push);
    bit found;
    found = 1'b0;
    case (act)
      hcu_pkg::ACT_START: begin
        for (int i = 0; i < hcu_pkg::MAX_CLASSES; i++) begin
          model_classes[i] = '0;
          model_counts[i]  = '0;
        end
        model_loaded = 0;
      end
      hcu_pkg::ACT_APPEND: begin
        if (model_loaded < hcu_pkg::MAX_CLASSES) begin
          model_classes[model_loaded] = val;
          model_counts[model_loaded]  = '0;
          model_loaded++;
          if (model_loaded > max_loaded) max_loaded = model_loaded;
        end else begin
          n_full++;
        end
      end
      hcu_pkg::ACT_PIXEL: begin
        for (int i = 0; i < model_loaded; i++) begin
          if (!found && model_classes[i] == val) begin
            found = 1'b1;
            if (model_counts[i] != hcu_pkg::COUNT_MAX) model_counts[i]++;
          end
        end
        if (found) n_hits++;
      end
      default: begin
        if (push) begin
          for (int i = 0; i < model_loaded; i++) begin
            expected_entries.push_back({model_classes[i], model_counts[i],
                                        (i + 1 == model_loaded)});
          end
        end
      end
    endcase
  endfunction

  function automatic logic [hcu_pkg::VAL_W-1:0] pick_class_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 7);
      3:       return -$urandom_range(1, 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [hcu_pkg::VAL_W-1:0] pick_pixel_value();
    if (model_loaded > 0 && $urandom_range(0, 3) != 0)
      return model_classes[$urandom_range(0, model_loaded - 1)];
    return pick_class_value();
  endfunction

  task automatic add_row(input hcu_pkg::action_e act, input logic [hcu_pkg::VAL_W-1:0] val,
                         input int n_typed, input hist_entry_t t0, input hist_entry_t t1);
    stim_row_t r;
    r.act     = act;
    r.val     = val;
    r.n_typed = n_typed;
    r.t0      = t0;
    r.t1      = t1;
    directed_rows.push_back(r);
  endtask

  // n_typed < 0: expectations come from the predictor
  task automatic run_request(input hcu_pkg::action_e act,
                             input logic [hcu_pkg::VAL_W-1:0] val,
                             input int n_typed, input hist_entry_t t0, input hist_entry_t t1);
    int gap;
    if ($urandom_range(0, 29) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.item_value <= val;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    apply_request(act, val, n_typed < 0);
    if (n_typed > 0) expected_entries.push_back(t0);
    if (n_typed > 1) expected_entries.push_back(t1);
    busy_items++;
    case (act)
      hcu_pkg::ACT_START:  n_start++;
      hcu_pkg::ACT_APPEND: n_append++;
      hcu_pkg::ACT_PIXEL:  n_pixel++;
      default:             n_read++;
    endcase
  endtask

  task automatic send(input hcu_pkg::action_e act, input logic [hcu_pkg::VAL_W-1:0] val);
    run_request(act, val, -1, '0, '0);
  endtask

  task automatic run_table_set(input int n_classes, input int n_pixels);
    send(hcu_pkg::ACT_START, $urandom);
    for (int i = 0; i < n_classes; i++) send(hcu_pkg::ACT_APPEND, pick_class_value());
    for (int i = 0; i < n_pixels; i++) send(hcu_pkg::ACT_PIXEL, pick_pixel_value());
    send(hcu_pkg::ACT_READ, $urandom);
  endtask

  task automatic note_mismatch(input string what, input hist_entry_t e, input hist_entry_t g);
    error_count++;
    if (error_count <= 10)
      $display("ERROR %s: expected value %h count %0d last %b, got value %h count %0d last %b",
               what, e.class_value, e.class_count, e.last_entry,
               g.class_value, g.class_count, g.last_entry);
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_entry = {out_if.class_value, out_if.class_count, out_if.last_entry};
      if (expected_entries.size() == 0) begin
        note_mismatch("unexpected result", '0, got_entry);
      end else begin
        exp_entry = expected_entries.pop_front();
        results_checked++;
        if (got_entry.class_value !== exp_entry.class_value ||
            got_entry.class_count !== exp_entry.class_count ||
            got_entry.last_entry  !== exp_entry.last_entry)
          note_mismatch("result mismatch", exp_entry, got_entry);
      end
    end
  end

  // Result side: random hold-offs, one long stall when armed
  initial begin
    int gap;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_arm) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_arm = 1'b0;
      end else begin
        if ($urandom_range(0, 29) == 0) recv_burst = ~recv_burst;
        gap = recv_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  initial begin
    int scenario;
    int k;
    in_if.valid      = 1'b0;
    in_if.action     = hcu_pkg::ACT_START;
    in_if.item_value = '0;
    rst_ni           = 1'b0;
    error_count      = 0;
    results_checked  = 0;
    busy_items       = 0;
    n_start = 0; n_append = 0; n_pixel = 0; n_read = 0;
    n_full = 0; n_hits = 0; max_loaded = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    hold_arm   = 1'b0;
    model_loaded = 0;
    for (int i = 0; i < hcu_pkg::MAX_CLASSES; i++) begin
      model_classes[i] = '0;
      model_counts[i]  = '0;
    end

    add_row(hcu_pkg::ACT_READ,   32'h0000_0000, 0, '0, '0);
    add_row(hcu_pkg::ACT_PIXEL,  32'h0000_0005, -1, '0, '0);
    add_row(hcu_pkg::ACT_APPEND, 32'h8000_0000, -1, '0, '0);
    add_row(hcu_pkg::ACT_APPEND, 32'h7FFF_FFFF, -1, '0, '0);
    add_row(hcu_pkg::ACT_PIXEL,  32'h8000_0000, -1, '0, '0);
    add_row(hcu_pkg::ACT_PIXEL,  32'h7FFF_FFFF, -1, '0, '0);
    add_row(hcu_pkg::ACT_PIXEL,  32'h7FFF_FFFF, -1, '0, '0);
    add_row(hcu_pkg::ACT_PIXEL,  32'h0000_0000, -1, '0, '0);
    add_row(hcu_pkg::ACT_READ,   32'h0000_0000, 2, {32'h8000_0000, 32'd1, 1'b0},
            {32'h7FFF_FFFF, 32'd2, 1'b1});
    add_row(hcu_pkg::ACT_READ,   32'hFFFF_FFFF, 2, {32'h8000_0000, 32'd1, 1'b0},
            {32'h7FFF_FFFF, 32'd2, 1'b1});
    add_row(hcu_pkg::ACT_START,  32'hFFFF_FFFF, -1, '0, '0);
    add_row(hcu_pkg::ACT_READ,   32'h0000_0000, 0, '0, '0);
    add_row(hcu_pkg::ACT_APPEND, 32'hFFFF_FFFF, -1, '0, '0);
    add_row(hcu_pkg::ACT_APPEND, 32'hFFFF_FFFF, -1, '0, '0);
    add_row(hcu_pkg::ACT_APPEND, 32'h0000_0000, -1, '0, '0);
    add_row(hcu_pkg::ACT_PIXEL,  32'hFFFF_FFFF, -1, '0, '0);
    add_row(hcu_pkg::ACT_PIXEL,  32'h0000_0000, -1, '0, '0);
    add_row(hcu_pkg::ACT_PIXEL,  32'hFFFF_FFFF, -1, '0, '0);
    add_row(hcu_pkg::ACT_READ,   32'h1234_5678, -1, '0, '0);
    add_row(hcu_pkg::ACT_START,  32'h0000_0000, -1, '0, '0);
    add_row(hcu_pkg::ACT_APPEND, 32'hAAAA_AAAA, 0, '0, '0);
    add_row(hcu_pkg::ACT_APPEND, 32'h5555_5555, 0, '0, '0);
    add_row(hcu_pkg::ACT_PIXEL,  32'h5555_5555, -1, '0, '0);
    add_row(hcu_pkg::ACT_READ,   32'h0000_0000, 2, {32'hAAAA_AAAA, 32'd0, 1'b0},
            {32'h5555_5555, 32'd1, 1'b1});

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      run_request(directed_rows[i].act, directed_rows[i].val, directed_rows[i].n_typed,
                  directed_rows[i].t0, directed_rows[i].t1);

    // full table, appends past full and repeated readouts against a stalled result side
    hold_arm = 1'b1;
    run_table_set(hcu_pkg::MAX_CLASSES + 2, 40);
    for (int i = 0; i < 20; i++) send(hcu_pkg::ACT_PIXEL, pick_pixel_value());
    send(hcu_pkg::ACT_READ, $urandom);
    send(hcu_pkg::ACT_APPEND, pick_class_value());
    send(hcu_pkg::ACT_READ, $urandom);

    while (busy_items < 420) begin
      scenario = $urandom_range(0, 9);
      if (scenario < 7) begin
        k = ($urandom_range(0, 9) == 0)
            ? $urandom_range(hcu_pkg::MAX_CLASSES - 2, hcu_pkg::MAX_CLASSES + 3)
            : $urandom_range(1, 8);
        run_table_set(k, $urandom_range(0, 25));
        if ($urandom_range(0, 2) == 0) begin
          for (int i = $urandom_range(1, 6); i > 0; i--)
            send(hcu_pkg::ACT_PIXEL, pick_pixel_value());
          send(hcu_pkg::ACT_READ, $urandom);
        end
      end else if (scenario == 7) begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          send($urandom_range(0, 1) ? hcu_pkg::ACT_APPEND : hcu_pkg::ACT_PIXEL,
               pick_pixel_value());
        send(hcu_pkg::ACT_READ, $urandom);
      end else begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          send(hcu_pkg::action_e'($urandom_range(0, 3)), $urandom);
      end
    end
    in_if.valid <= 1'b0;

    while (expected_entries.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Requests: %0d start, %0d append (%0d full), %0d pixel (%0d hits), %0d readout",
             n_start, n_append, n_full, n_pixel, n_read, n_hits);
    $display("Results checked: %0d, largest table %0d entries, mismatches %0d",
             results_checked, max_loaded, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Timeout with %0d results outstanding", expected_entries.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/hcu_pkg.sv
sv/hcu_in_if.sv
sv/hcu_out_if.sv
sv/hcu_ram.sv
sv/hcu_ctrl.sv
sv/hcu_dp.sv
sv/class_histogram_counter_unit.sv
dv/tb_class_histogram_counter_unit.sv
